// ===== rtl/dqm_pkg.sv =====
// shared types, codes and term table of the dual quaternion multiplier
package dqm_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_W         = 32;
    localparam int OPW           = VAL_W + 1;
    localparam int PROD_W        = 2 * OPW;

    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    localparam logic [2:0] MODE_AB    = 3'd0;
    localparam logic [2:0] MODE_ABA   = 3'd1;
    localparam logic [2:0] MODE_CONJ  = 3'd2;
    localparam logic [2:0] MODE_DUAL  = 3'd3;
    localparam logic [2:0] MODE_QCONJ = 3'd4;

    localparam logic [2:0] SLOT_LAST = 3'd7;

    // one byte per term: [7] used, [6] subtract, [5:3] left index, [2:0] right index
    // eight terms per component, component rows in slot order
    localparam logic [7:0] TERM_TAB [64] = '{
        8'h80, 8'hC9, 8'hD2, 8'hDB, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h81, 8'h88, 8'h93, 8'hDA, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h82, 8'h90, 8'hCB, 8'h99, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h83, 8'h98, 8'h8A, 8'hD1, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hA0, 8'h84, 8'hB9, 8'h8F, 8'hF2, 8'h96, 8'hAB, 8'hDD,
        8'hA8, 8'h85, 8'hB1, 8'hCE, 8'hBA, 8'h97, 8'hE3, 8'h9C,
        8'hB0, 8'h86, 8'hE9, 8'h8D, 8'hA2, 8'hD4, 8'hBB, 8'h9F,
        8'hB8, 8'h87, 8'hCC, 8'hE1, 8'hD5, 8'hEA, 8'hDE, 8'hF3
    };

    // components of A negated in the right-hand factor of a sandwich
    function automatic logic [7:0] dqm_neg_mask(input logic [2:0] mode);
        logic [7:0] mask;
        case (mode)
            MODE_CONJ:  mask = 8'h7E;
            MODE_DUAL:  mask = 8'hF0;
            MODE_QCONJ: mask = 8'h8E;
            default:    mask = 8'h00;
        endcase
        return mask;
    endfunction

    typedef struct packed {
        logic       valid;
        logic [2:0] comp;
        logic [2:0] term;
        logic       second;
        logic       last_pass;
        logic [2:0] mode;
    } t_issue;

    typedef struct packed {
        logic       valid;
        logic       neg;
        logic       first;
        logic       last;
        logic [2:0] comp;
        logic       last_pass;
    } t_mac_ctl;

    typedef struct packed {
        logic                    valid;
        logic [2:0]              comp;
        logic                    last_pass;
        logic signed [VAL_W-1:0] value;
    } t_mac_res;

endpackage

// ===== rtl/dqm_if.sv =====
// valid/ready channel interfaces for input items and result items
interface dqm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [2:0]  slot;
    logic signed [31:0] value;
    logic [2:0]  mode;

    modport source (output valid, output opcode, output slot, output value, output mode,
                    input ready);
    modport sink   (input valid, input opcode, input slot, input value, input mode,
                    output ready);
endinterface

interface dqm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  out_slot;
    logic signed [31:0] out_value;
    logic        last;

    modport source (output valid, output out_slot, output out_value, output last,
                    input ready);
    modport sink   (input valid, input out_slot, input out_value, input last,
                    output ready);
endinterface

// ===== rtl/dqm_mac.sv =====
// shared multiply, floor shift, accumulate and saturate unit
module dqm_mac import dqm_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_mac_ctl              i_ctl,
    input  logic signed [OPW-1:0] i_op_p,
    input  logic signed [OPW-1:0] i_op_q,
    output t_mac_res              o_res
);

    localparam int ACC_W = PROD_W - FRAC_BITS + 3;
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W - VAL_W + 1){1'b0}}, {(VAL_W - 1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W - VAL_W + 1){1'b1}}, {(VAL_W - 1){1'b0}}};

    logic signed [PROD_W-1:0] r_prod;
    t_mac_ctl                 r_ctl;
    logic signed [ACC_W-1:0]  r_acc;

    logic signed [PROD_W-1:0] w_shift;
    logic signed [ACC_W-1:0]  w_term;
    logic signed [ACC_W-1:0]  n_acc;
    logic signed [VAL_W-1:0]  w_sat;

    // arithmetic shift of the exact product is the floor
    assign w_shift = r_prod >>> FRAC_BITS;
    assign w_term  = r_ctl.neg ? -w_shift[ACC_W-1:0] : w_shift[ACC_W-1:0];
    assign n_acc   = (r_ctl.first ? ACC_W'(0) : r_acc) + w_term;

    always_comb begin
        if (n_acc > SAT_MAX) begin
            w_sat = SAT_MAX[VAL_W-1:0];
        end else if (n_acc < SAT_MIN) begin
            w_sat = SAT_MIN[VAL_W-1:0];
        end else begin
            w_sat = n_acc[VAL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_op_p) * PROD_W'(i_op_q);
        if (r_ctl.valid) begin
            r_acc <= n_acc;
        end
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    assign o_res.valid     = r_ctl.valid && r_ctl.last;
    assign o_res.comp      = r_ctl.comp;
    assign o_res.last_pass = r_ctl.last_pass;
    assign o_res.value     = w_sat;

endmodule

// ===== rtl/dqm_seq.sv =====
// sequencer: term issue over one or two passes, then result emission
module dqm_seq import dqm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_opcode,
    input  logic [2:0] i_mode,
    output logic       o_in_ready,
    input  logic       i_wb_done,
    input  logic       i_out_ready,
    output logic       o_out_valid,
    output logic [2:0] o_out_slot,
    output t_issue     o_issue
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_WAIT, S_EMIT} t_state;

    t_state     r_state;
    logic [5:0] r_cnt;
    logic       r_pass;
    logic [2:0] r_mode;
    logic [2:0] r_slot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_pass  <= 1'b0;
            r_mode  <= MODE_AB;
            r_slot  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_opcode == OP_COMPUTE) begin
                        r_state <= S_RUN;
                        r_cnt   <= '0;
                        r_pass  <= 1'b0;
                        if (i_mode inside {MODE_ABA, MODE_CONJ, MODE_DUAL, MODE_QCONJ}) begin
                            r_mode <= i_mode;
                        end else begin
                            r_mode <= MODE_AB;
                        end
                    end
                end
                S_RUN: begin
                    r_cnt <= r_cnt + 6'd1;
                    if (&r_cnt) begin
                        if (!r_pass && r_mode != MODE_AB) begin
                            r_pass <= 1'b1;
                        end else begin
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (i_wb_done) begin
                        r_state <= S_EMIT;
                        r_slot  <= '0;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        if (r_slot == SLOT_LAST) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_slot <= r_slot + 3'd1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT);
    assign o_out_slot  = r_slot;

    assign o_issue.valid     = (r_state == S_RUN);
    assign o_issue.comp      = r_cnt[5:3];
    assign o_issue.term      = r_cnt[2:0];
    assign o_issue.second    = r_pass;
    assign o_issue.last_pass = r_pass || (r_mode == MODE_AB);
    assign o_issue.mode      = r_mode;

endmodule

// ===== rtl/dual_quaternion_multiply.sv =====
// top level: operand stores, term operand selection and result buffer
// Dual quaternion multiplier with sandwich modes, signed fixed point with FRAC_BITS
// fraction bits. Load items (opcode load A / load B) write one of the eight
// components of operand A or B and are taken back to back while the block is idle;
// they produce no result. A compute item forms P = A*B and, for modes 1 to 4, then
// P*X, X being A with the mode's components negated (none in mode 1); modes 5
// to 7 act as mode 0. Each component is the sum of up to eight products, each
// floored after the fraction shift, and the sum saturates to 32 bits; a sandwich
// feeds the saturated P into the second product. All products go through one
// 33x33 multiplier, one term per cycle, eight term slots per component. A compute
// holds the input side for one product pass (mode 0) or two (sandwich modes) and
// the pipeline drain, then hands out the eight result items in slot order, last
// set on slot 7, one per cycle while the sink takes them. Items are accepted again
// once the eighth result has been taken. Operand components read before they were
// ever written give undefined results.
module dual_quaternion_multiply import dqm_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dqm_in_if.sink      i_in,
    dqm_out_if.source   o_out
);

    // operand stores, intermediate product and result buffer
    logic signed [VAL_W-1:0] r_a [8];
    logic signed [VAL_W-1:0] r_b [8];
    logic signed [VAL_W-1:0] r_p [8];
    logic signed [VAL_W-1:0] r_r [8];

    t_issue     w_issue;
    t_mac_ctl   w_ctl;
    t_mac_res   w_res;
    logic       w_wb_done;
    logic       w_accept;
    logic [2:0] w_out_slot;

    // term decode
    logic [7:0] w_tab;
    logic       w_use;
    logic       w_neg;
    logic [2:0] w_pi;
    logic [2:0] w_qi;
    logic [7:0] w_mask;
    logic signed [OPW-1:0] w_a_p;
    logic signed [OPW-1:0] w_a_q;
    logic signed [OPW-1:0] w_op_p;
    logic signed [OPW-1:0] w_op_q;

    assign w_accept = i_in.valid && i_in.ready;

    dqm_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_opcode    (i_in.opcode),
        .i_mode      (i_in.mode),
        .o_in_ready  (i_in.ready),
        .i_wb_done   (w_wb_done),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_out_slot  (w_out_slot),
        .o_issue     (w_issue)
    );

    // table entry for the current component and term slot
    assign w_tab  = TERM_TAB[{w_issue.comp, w_issue.term}];
    assign w_use  = w_tab[7];
    assign w_neg  = w_tab[6];
    assign w_pi   = w_tab[5:3];
    assign w_qi   = w_tab[2:0];
    assign w_mask = dqm_neg_mask(w_issue.mode);

    // A components widened so that negating the most negative value stays exact
    assign w_a_p = {r_a[w_pi][VAL_W-1], r_a[w_pi]};
    assign w_a_q = {r_a[w_qi][VAL_W-1], r_a[w_qi]};

    always_comb begin
        if (!w_use) begin
            // empty term slot of a real part contributes zero
            w_op_p = '0;
            w_op_q = '0;
        end else if (w_issue.second) begin
            // second pass: P times A with the mode's sign pattern
            w_op_p = {r_p[w_pi][VAL_W-1], r_p[w_pi]};
            w_op_q = w_mask[w_qi] ? -w_a_q : w_a_q;
        end else begin
            w_op_p = w_a_p;
            w_op_q = {r_b[w_qi][VAL_W-1], r_b[w_qi]};
        end
    end

    assign w_ctl.valid     = w_issue.valid;
    assign w_ctl.neg       = w_neg;
    assign w_ctl.first     = (w_issue.term == 3'd0);
    assign w_ctl.last      = &w_issue.term;
    assign w_ctl.comp      = w_issue.comp;
    assign w_ctl.last_pass = w_issue.last_pass;

    dqm_mac #(
        .FRAC_BITS (FRAC_BITS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_op_p  (w_op_p),
        .i_op_q  (w_op_q),
        .o_res   (w_res)
    );

    // the final component of the final pass lands in the result buffer
    assign w_wb_done = w_res.valid && w_res.last_pass && (w_res.comp == SLOT_LAST);

    // store writes: loads from the input side, component sums from the unit;
    // a second pass reads component 7 of P only after its first four components,
    // long after the first pass wrote it
    always_ff @(posedge i_clk) begin
        if (w_accept && i_in.opcode == OP_LOAD_A) begin
            r_a[i_in.slot] <= i_in.value;
        end
        if (w_accept && i_in.opcode == OP_LOAD_B) begin
            r_b[i_in.slot] <= i_in.value;
        end
        if (w_res.valid) begin
            if (w_res.last_pass) begin
                r_r[w_res.comp] <= w_res.value;
            end else begin
                r_p[w_res.comp] <= w_res.value;
            end
        end
    end

    // result side reads the buffer at the emission counter
    assign o_out.out_slot  = w_out_slot;
    assign o_out.out_value = r_r[w_out_slot];
    assign o_out.last      = (w_out_slot == SLOT_LAST);

`ifndef SYNTHESIS
    // no new item while results are being handed out
    a_emit_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> !i_in.ready)
        else $error("input ready while results pending");

    // a compute item closes the input side on the next cycle
    a_compute_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.opcode == OP_COMPUTE) |=> !i_in.ready)
        else $error("input ready right after compute");

    // last component written means emission starts at slot 0
    a_wb_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wb_done |=> (o_out.valid && o_out.out_slot == 3'd0))
        else $error("emission did not start after final component");

    // taking the last result frees the input side
    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.ready && o_out.last) |=> i_in.ready)
        else $error("input not ready after last result");

    // the unit is never fed while results are handed out
    a_no_issue_in_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue.valid |-> !o_out.valid)
        else $error("term issued during emission");
`endif

endmodule

// ===== tb/dual_quaternion_multiply_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the dual quaternion multiplier with sandwich modes
module dual_quaternion_multiply_tb;
    import dqm_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int RAND_ITEMS  = 95;
    // a compute holds the input side for one or two product passes, then the
    // receiver may stall; this limit is several times the worst quiet stretch
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = 40;

    // codes the block has no use for
    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam logic [2:0] MODE_UNUSED = 3'd7;

    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] Q_ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MONE = 32'shFFFF_0000;

    localparam logic signed [69:0] SUM_MAX = 70'sd2147483647;
    localparam logic signed [69:0] SUM_MIN = -70'sd2147483648;

    // directed operands: full-scale values force saturation, and the minimum
    // in negated slots of A checks that -(-2^31) is carried as +2^31
    localparam logic signed [31:0] EDGE_A [8] = '{
        Q_MAX, Q_MIN, Q_ONE, Q_MONE, Q_MIN, Q_MAX, 32'sd0, Q_MIN
    };
    localparam logic signed [31:0] EDGE_B [8] = '{
        Q_MAX, Q_MAX, Q_MIN, 32'sh0001_8000, 32'sd1, -32'sd1, Q_MAX, Q_MIN
    };

    // one component with room for a negated minimum
    typedef logic signed [32:0] t_comp;
    typedef logic [7:0][32:0]   t_dq;

    typedef struct {
        logic [1:0]         opcode;
        logic [2:0]         slot;
        logic signed [31:0] value;
        logic [2:0]         mode;
        bit                 drain;  // hold back until every result so far has come
    } t_op_item;

    typedef struct {
        logic [2:0]         slot;
        logic signed [31:0] value;
        logic               last;
    } t_comp_result;

    logic i_clk;
    logic i_rst_n;

    dqm_in_if  op_bus ();
    dqm_out_if res_bus ();

    dual_quaternion_multiply #(
        .FRAC_BITS (FRAC)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (op_bus),
        .o_out   (res_bus)
    );

    // predictor state: operand stores as the block should hold them
    logic signed [31:0] opnd_a [8];
    logic signed [31:0] opnd_b [8];

    t_op_item     staged_items [$];
    t_comp_result due_components [$];
    t_op_item     on_bus;

    int burst_left;
    int gap_left;
    int ready_style;
    int style_left;
    int ready_tick;
    int quiet_cycles;
    int fail_count;
    bit run_done;

    // one elementary product, floored after the fraction shift
    function automatic logic signed [65:0] mt(input t_dq p, input t_dq q,
                                              input int a, input int b);
        t_comp              x;
        t_comp              y;
        logic signed [65:0] prod;
        x    = p[a];
        y    = q[b];
        prod = x * y;
        return prod >>> FRAC;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [69:0] s);
        if (s > SUM_MAX) return Q_MAX;
        if (s < SUM_MIN) return Q_MIN;
        return s[31:0];
    endfunction

    // dual quaternion product: i*i = j*j = k*k = -1, i*j = k, e*e = 0
    function automatic t_dq dq_product(input t_dq p, input t_dq q);
        logic signed [69:0] t [8];
        t_dq                r;
        t[0] = mt(p, q, 0, 0) - mt(p, q, 1, 1) - mt(p, q, 2, 2) - mt(p, q, 3, 3);
        t[1] = mt(p, q, 0, 1) + mt(p, q, 1, 0) + mt(p, q, 2, 3) - mt(p, q, 3, 2);
        t[2] = mt(p, q, 0, 2) + mt(p, q, 2, 0) - mt(p, q, 1, 3) + mt(p, q, 3, 1);
        t[3] = mt(p, q, 0, 3) + mt(p, q, 3, 0) + mt(p, q, 1, 2) - mt(p, q, 2, 1);
        t[4] = mt(p, q, 4, 0) + mt(p, q, 0, 4) + mt(p, q, 7, 1) + mt(p, q, 1, 7)
             - mt(p, q, 6, 2) + mt(p, q, 2, 6) + mt(p, q, 5, 3) - mt(p, q, 3, 5);
        t[5] = mt(p, q, 5, 0) + mt(p, q, 0, 5) + mt(p, q, 6, 1) - mt(p, q, 1, 6)
             + mt(p, q, 7, 2) + mt(p, q, 2, 7) - mt(p, q, 4, 3) + mt(p, q, 3, 4);
        t[6] = mt(p, q, 6, 0) + mt(p, q, 0, 6) - mt(p, q, 5, 1) + mt(p, q, 1, 5)
             + mt(p, q, 4, 2) - mt(p, q, 2, 4) + mt(p, q, 7, 3) + mt(p, q, 3, 7);
        t[7] = mt(p, q, 7, 0) + mt(p, q, 0, 7) - mt(p, q, 1, 4) - mt(p, q, 4, 1)
             - mt(p, q, 2, 5) - mt(p, q, 5, 2) - mt(p, q, 3, 6) - mt(p, q, 6, 3);
        for (int i = 0; i < 8; i++) begin
            r[i] = t_comp'(sat32(t[i]));
        end
        return r;
    endfunction

    // components of A negated in the right-hand factor of a sandwich
    function automatic logic [7:0] conj_mask(input logic [2:0] mode);
        case (mode)
            MODE_CONJ:  return 8'b0111_1110;  // both vector parts
            MODE_DUAL:  return 8'b1111_0000;  // the whole dual half
            MODE_QCONJ: return 8'b1000_1110;  // vector part and e
            default:    return 8'b0000_0000;
        endcase
    endfunction

    // update the operand stores, or queue the eight components a compute yields
    task automatic absorb_item(input t_op_item it);
        t_dq          pa;
        t_dq          pb;
        t_dq          x;
        t_dq          prod;
        logic [7:0]   neg;
        t_comp_result cr;
        case (it.opcode)
            OP_LOAD_A: opnd_a[it.slot] = it.value;
            OP_LOAD_B: opnd_b[it.slot] = it.value;
            OP_COMPUTE: begin
                for (int i = 0; i < 8; i++) begin
                    pa[i] = t_comp'(opnd_a[i]);
                    pb[i] = t_comp'(opnd_b[i]);
                end
                prod = dq_product(pa, pb);
                // unused modes fall back to the plain product
                if (it.mode >= MODE_ABA && it.mode <= MODE_QCONJ) begin
                    neg = conj_mask(it.mode);
                    for (int i = 0; i < 8; i++) begin
                        x[i] = neg[i] ? -t_comp'(opnd_a[i]) : t_comp'(opnd_a[i]);
                    end
                    prod = dq_product(prod, x);
                end
                for (int k = 0; k < 8; k++) begin
                    cr.slot  = k[2:0];
                    cr.value = prod[k][31:0];
                    cr.last  = (k[2:0] == SLOT_LAST);
                    due_components.push_back(cr);
                end
            end
            default: ;  // unused opcode leaves everything alone
        endcase
    endtask

    task automatic stage(input logic [1:0] opcode, input logic [2:0] slot,
                         input logic signed [31:0] value, input logic [2:0] mode,
                         input bit drain);
        t_op_item it;
        it.opcode = opcode;
        it.slot   = slot;
        it.value  = value;
        it.mode   = mode;
        it.drain  = drain;
        staged_items.push_back(it);
    endtask

    // mostly modest Q16.16 magnitudes, with corners and raw words mixed in
    function automatic logic signed [31:0] pick_value();
        int unsigned        sel;
        logic signed [31:0] v;
        sel = $urandom_range(0, 99);
        if (sel < 15) begin
            case ($urandom_range(0, 5))
                0:       v = Q_MAX;
                1:       v = Q_MIN;
                2:       v = Q_ONE;
                3:       v = Q_MONE;
                4:       v = -32'sd1;
                default: v = 32'sd0;
            endcase
        end else if (sel < 70) begin
            v = $urandom_range(0, 32'h8_0000) - 32'h4_0000;  // within +-4.0
        end else begin
            v = $urandom;
        end
        return v;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // stimulus and end of run
    initial begin
        int n_items;
        int n_loads;
        op_bus.valid  = 1'b0;
        op_bus.opcode = OP_LOAD_A;
        op_bus.slot   = 3'd0;
        op_bus.value  = 32'sd0;
        op_bus.mode   = MODE_AB;
        res_bus.ready = 1'b0;
        i_rst_n       = 1'b0;
        run_done      = 1'b0;
        fail_count    = 0;

        // directed: fill every component first, so nothing unwritten is ever read
        for (int i = 0; i < 8; i++) begin
            stage(OP_LOAD_A, i[2:0], EDGE_A[i], 3'($urandom), 1'b0);
            stage(OP_LOAD_B, i[2:0], EDGE_B[i], 3'($urandom), 1'b0);
        end
        stage(OP_COMPUTE, 3'($urandom), $urandom, MODE_AB, 1'b0);
        stage(OP_COMPUTE, 3'($urandom), $urandom, MODE_ABA, 1'b0);
        stage(OP_UNUSED, 3'($urandom), $urandom, 3'($urandom), 1'b0);
        stage(OP_COMPUTE, 3'($urandom), $urandom, MODE_CONJ, 1'b0);
        // wait for the block to drain completely before this one
        stage(OP_COMPUTE, 3'($urandom), $urandom, MODE_DUAL, 1'b1);
        stage(OP_COMPUTE, 3'($urandom), $urandom, MODE_QCONJ, 1'b0);
        stage(OP_COMPUTE, 3'($urandom), $urandom, MODE_UNUSED, 1'b0);

        // random: runs of loads closed by a compute, with ignored items as noise
        n_items = 0;
        while (n_items < RAND_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
                stage(OP_UNUSED, 3'($urandom), $urandom, 3'($urandom), 1'b0);
            end else begin
                n_loads = $urandom_range(1, 8);
                repeat (n_loads) begin
                    stage($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A, 3'($urandom),
                          pick_value(), 3'($urandom), 1'b0);
                end
                stage(OP_COMPUTE, 3'($urandom), $urandom,
                      3'($urandom_range(0, 9) < 8 ? $urandom_range(0, 4)
                                                  : $urandom_range(5, 7)),
                      $urandom_range(0, 9) == 0);
                n_items += n_loads + 1;
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (staged_items.size() != 0 || op_bus.valid || due_components.size() != 0) begin
            @(posedge i_clk);
        end
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge i_clk);
        run_done = 1'b1;
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // driver: bursts of items with random gaps; valid holds until the item is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            op_bus.valid  <= 1'b0;
            op_bus.opcode <= OP_LOAD_A;
            op_bus.slot   <= 3'd0;
            op_bus.value  <= 32'sd0;
            op_bus.mode   <= MODE_AB;
            burst_left = $urandom_range(1, 8);
            gap_left   = 0;
        end else begin
            if (op_bus.valid && op_bus.ready) begin
                absorb_item(on_bus);
            end
            if (op_bus.valid && !op_bus.ready) begin
                // item still waiting for the block
            end else if (gap_left > 0) begin
                gap_left--;
                op_bus.valid <= 1'b0;
            end else if (staged_items.size() == 0 ||
                         (staged_items[0].drain && due_components.size() != 0)) begin
                op_bus.valid <= 1'b0;
            end else begin
                on_bus = staged_items.pop_front();
                op_bus.valid  <= 1'b1;
                op_bus.opcode <= on_bus.opcode;
                op_bus.slot   <= on_bus.slot;
                op_bus.value  <= on_bus.value;
                op_bus.mode   <= on_bus.mode;
                burst_left--;
                if (burst_left <= 0) begin
                    // now and then a long burst with no idling at all
                    burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
        end
    end

    // monitor: checks each taken result against the oldest expected component
    always @(posedge i_clk) begin
        t_comp_result want;
        if (!i_rst_n) begin
            res_bus.ready <= 1'b0;
            ready_style = 0;
            style_left  = 0;
            ready_tick  = 0;
        end else begin
            if (res_bus.valid && res_bus.ready) begin
                if (due_components.size() == 0) begin
                    $error("unexpected result: out_slot %0d out_value %h",
                           res_bus.out_slot, res_bus.out_value);
                    fail_count++;
                end else begin
                    want = due_components.pop_front();
                    if (res_bus.out_slot !== want.slot) begin
                        $error("out_slot: expected %0d, got %0d", want.slot, res_bus.out_slot);
                        fail_count++;
                    end
                    if (res_bus.out_value !== want.value) begin
                        $error("out_value: expected %h, got %h", want.value, res_bus.out_value);
                        fail_count++;
                    end
                    if (res_bus.last !== want.last) begin
                        $error("last: expected %0b, got %0b", want.last, res_bus.last);
                        fail_count++;
                    end
                end
            end

            // stall pattern switches style over stretches of random length
            if (style_left == 0) begin
                ready_style = $urandom_range(0, 3);
                style_left  = $urandom_range(20, 300);
            end else begin
                style_left--;
            end
            ready_tick++;
            case (ready_style)
                0:       res_bus.ready <= 1'b1;
                1:       res_bus.ready <= ($urandom_range(0, 1) == 1);
                2:       res_bus.ready <= (ready_tick % 4 == 3);
                default: res_bus.ready <= (ready_tick % 32 >= 20);  // long stalls
            endcase
        end
    end

    // watchdog: too long with nothing taken on either side ends the run
    always @(posedge i_clk) begin
        if (!i_rst_n || run_done) begin
            quiet_cycles = 0;
        end else if ((op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready)) begin
            quiet_cycles = 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles++;
        end
    end

endmodule

// ===== sim.f =====
rtl/dqm_pkg.sv
rtl/dqm_if.sv
rtl/dqm_mac.sv
rtl/dqm_seq.sv
rtl/dual_quaternion_multiply.sv
tb/dual_quaternion_multiply_tb.sv
